[rtl/sbsd_pkg.sv]
// ----------------------------------------------------------------------------
// Signed binary-search divider package
// Shared types and constants for the divider and its pipeline.
// ----------------------------------------------------------------------------
package sbsd_pkg;

  localparam int DataWidth = 32;

  // One division request.
  typedef struct packed {
    logic signed [DataWidth-1:0] dividend;
    logic signed [DataWidth-1:0] divisor;
  } sbsd_req_t;

  // One division result.
  typedef struct packed {
    logic signed [DataWidth-1:0] quotient;
    logic                        divide_by_zero;
  } sbsd_rsp_t;

endpackage

[rtl/sbsd_pipe.sv]
// ----------------------------------------------------------------------------
// Divider pipeline
// One stage per quotient bit, searching the quotient from the top bit down.
// ----------------------------------------------------------------------------
module sbsd_pipe #(
  parameter int DATA_WIDTH = sbsd_pkg::DataWidth
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  in_valid,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  output logic                  out_valid,
  output logic [DATA_WIDTH-1:0] quotient,
  output logic                  divide_by_zero
);
  localparam int W      = DATA_WIDTH;
  localparam int Stages = W + 2;

  // Stage registers: index 0 is the sign stage, 1..W the search steps,
  // W+1 the sign and saturation fix-up.
  logic [Stages-1:0] valid;
  logic [W:0]        rem  [Stages];
  logic [W:0]        dmag [Stages];
  logic [W-1:0]      qbit [Stages];
  logic              neg  [Stages];
  logic              dz   [Stages];
  logic [W-1:0]      qout;
  logic              dzout;

  logic [W:0] mag_a;
  logic [W:0] mag_b;
  logic       a_pos;
  logic       b_pos;

  // Entry: magnitudes at one extra bit so the most negative value fits.
  always_comb begin
    mag_a = dividend[W-1] ? ({1'b0, ~dividend} + {{W{1'b0}}, 1'b1})
                          : {1'b0, dividend};
    mag_b = divisor[W-1]  ? ({1'b0, ~divisor} + {{W{1'b0}}, 1'b1})
                          : {1'b0, divisor};
    a_pos = (dividend != '0) && !dividend[W-1];
    b_pos = (divisor != '0) && !divisor[W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      valid     <= {valid[Stages-2:0], in_valid};
      out_valid <= valid[Stages-1];
    end
  end

  // Stage 0 captures operands; each later stage tries one quotient bit.
  always_ff @(posedge clk) begin
    if (advance) begin
      rem[0]  <= mag_a;
      dmag[0] <= mag_b;
      qbit[0] <= '0;
      neg[0]  <= !((a_pos && b_pos) || (dividend[W-1] && divisor[W-1]));
      dz[0]   <= (divisor == '0);
      for (int s = 1; s < Stages; s++) begin
        dmag[s] <= dmag[s-1];
        neg[s]  <= neg[s-1];
        dz[s]   <= dz[s-1];
      end
      for (int s = 1; s <= W; s++) begin
        // Bit W-s: keep it when (q | bit) * |divisor| still fits.
        if (!dz[s-1] && ((rem[s-1] >> (W - s)) >= dmag[s-1])) begin
          rem[s]  <= rem[s-1] - (dmag[s-1] << (W - s));
          qbit[s] <= qbit[s-1] | ({{(W-1){1'b0}}, 1'b1} << (W - s));
        end else begin
          rem[s]  <= rem[s-1];
          qbit[s] <= qbit[s-1];
        end
      end
      rem[Stages-1]  <= rem[Stages-2];
      qbit[Stages-1] <= qbit[Stages-2];
    end
  end

  // Final stage: sign, saturation, and the zero-divisor value.
  always_ff @(posedge clk) begin
    if (advance) begin
      dzout <= dz[Stages-1];
      if (dz[Stages-1]) begin
        qout <= W'(~rem[Stages-1] + 1'b1);
      end else if (neg[Stages-1]) begin
        qout <= ~qbit[Stages-1] + 1'b1;
      end else if (qbit[Stages-1][W-1]) begin
        qout <= {1'b0, {(W-1){1'b1}}};
      end else begin
        qout <= qbit[Stages-1];
      end
    end
  end

  assign quotient       = qout;
  assign divide_by_zero = dzout;

  // A result leaves only after the last stage held a valid item.
  a_out_follows: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(valid[Stages-1]))
    else $error("result without item in last stage");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !$past(advance) && !$past(rst) |-> $stable(valid))
    else $error("pipeline moved during a stall");
  // Minus a magnitude is never strictly positive.
  a_no_res_dz: assert property (@(posedge clk) disable iff (rst)
    out_valid && dzout |-> (qout == '0 || qout[W-1]))
    else $error("divide-by-zero result malformed");
endmodule

[rtl/signed_binary_search_divider.sv]
// ----------------------------------------------------------------------------
// Signed binary-search divider
// Truncating signed division, pipelined one quotient bit per stage.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake       | Payload
// req     | in        | req_valid/ready | dividend, divisor
// rsp     | out       | rsp_valid/ready | quotient, divide_by_zero
//
// The path runs through one sign stage, one stage per quotient bit, one
// fix-up stage and the output register.
// A new request may enter every cycle unless the pipeline holds. The whole pipeline holds while a
// result waits and rsp_ready is low; nothing is lost or repeated.
// Reset clears every valid bit; data registers are not reset.
// ----------------------------------------------------------------------------
module signed_binary_search_divider (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  sbsd_pkg::sbsd_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output sbsd_pkg::sbsd_rsp_t rsp
);
  import sbsd_pkg::*;

  logic                 advance;
  logic [DataWidth-1:0] quot;
  logic                 dz;

  // The pipeline moves unless a finished result is being held.
  assign advance   = !rsp_valid || rsp_ready;
  assign req_ready = advance;

  sbsd_pipe #(.DATA_WIDTH(DataWidth)) u_pipe (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .in_valid       (req_valid),
    .dividend       (req.dividend),
    .divisor        (req.divisor),
    .out_valid      (rsp_valid),
    .quotient       (quot),
    .divide_by_zero (dz)
  );

  assign rsp.quotient       = quot;
  assign rsp.divide_by_zero = dz;

  // A held result stays unchanged while stalled.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("request refused with empty output");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("request taken during stall");
endmodule

[sim/tb_signed_binary_search_divider.sv]
// ----------------------------------------------------------------------------
// Signed binary-search divider testbench
// Drives division requests with random gaps, takes each expected quotient and the
// divide-by-zero flag from the directed table or a prediction, and checks every response in order under random stalls.
// ----------------------------------------------------------------------------
module tb_signed_binary_search_divider;
  import sbsd_pkg::*;

  localparam int W          = DataWidth;
  localparam int NumRandom  = 500;
  localparam int CycleLimit = 200000;
  localparam int Latency    = W + 3;

  localparam logic signed [W-1:0] MaxPos = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MinNeg = {1'b1, {(W-1){1'b0}}};

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  sbsd_req_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  sbsd_rsp_t rsp;

  signed_binary_search_divider dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready),
    .req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Directed row: operands, and an optional typed-in expectation.
  typedef struct {
    logic signed [W-1:0] dividend;
    logic signed [W-1:0] divisor;
    bit                  known;
    logic signed [W-1:0] quotient;
    logic                dbz;
  } div_row_t;

  sbsd_rsp_t quotient_queue[$];
  int        mismatches = 0;
  int        cycles = 0;

  // Magnitude of a two's complement word; the most negative maps to 2^(W-1).
  function automatic logic [W:0] abs_word(logic signed [W-1:0] v);
    logic [W:0] ext;
    ext = {v[W-1], v};
    return v[W-1] ? (~ext + 1'b1) : ext;
  endfunction

  // Expected response for one division request.
  function automatic sbsd_rsp_t predict_quotient(logic signed [W-1:0] a,
                                                 logic signed [W-1:0] b);
    sbsd_rsp_t  r;
    logic [W:0] ma, mb, q;
    logic       same;
    ma = abs_word(a);
    mb = abs_word(b);
    same = ((a != 0) && !a[W-1] && (b != 0) && !b[W-1]) || (a[W-1] && b[W-1]);
    r.divide_by_zero = 1'b0;
    if (mb == 0) begin
      r.quotient = -ma[W-1:0];
      r.divide_by_zero = 1'b1;
    end else begin
      q = ma / mb;
      if (same) begin
        r.quotient = (q > {1'b0, MaxPos}) ? MaxPos : q[W-1:0];
      end else begin
        r.quotient = -q[W-1:0];
      end
    end
    return r;
  endfunction

  function automatic logic signed [W-1:0] rand_operand();
    logic [W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = $urandom_range(0, 3);
      1: v = -$urandom_range(0, 3);
      2: v = $urandom_range(0, 255);
      3: v = -$urandom_range(0, 255);
      4: v = $urandom >> $urandom_range(0, W-1);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Send one request after a random gap, recording its expectation.
  // Valid drops only for a gap before a request, so back-to-back requests keep it high.
  task automatic send_request(logic signed [W-1:0] a, logic signed [W-1:0] b,
                              sbsd_rsp_t exp_rsp);
    int gap;
    gap = $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req.dividend <= a;
    req.divisor <= b;
    quotient_queue.push_back(exp_rsp);
    do @(posedge clk); while (!req_ready);
  endtask

  // Response side: random stalls per result, compare against oldest request.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      if (quotient_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected response: %p", rsp);
      end else begin
        sbsd_rsp_t e;
        e = quotient_queue.pop_front();
        if (rsp.quotient !== e.quotient || rsp.divide_by_zero !== e.divide_by_zero) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected q=%0d dbz=%0b, got q=%0d dbz=%0b",
                     e.quotient, e.divide_by_zero, rsp.quotient, rsp.divide_by_zero);
        end
      end
    end
  end

  // Cycle limit guards against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stimulus: directed table, then random requests.
  initial begin
    div_row_t  rows[$];
    sbsd_rsp_t e;
    logic signed [W-1:0] a, b;
    rows = '{
      '{32'sd0,   32'sd1,  1, 32'sd0,  1'b0},
      '{32'sd7,   32'sd0,  1, -32'sd7, 1'b1},
      '{-32'sd7,  32'sd0,  1, -32'sd7, 1'b1},
      '{32'sd0,   32'sd0,  1, 32'sd0,  1'b1},
      '{MinNeg,   32'sd0,  1, MinNeg,  1'b1},
      '{MaxPos,   32'sd0,  1, MinNeg + 1, 1'b1},
      '{MinNeg,  -32'sd1,  1, MaxPos,  1'b0},
      '{MinNeg,   32'sd1,  1, MinNeg,  1'b0},
      '{MaxPos,   32'sd1,  1, MaxPos,  1'b0},
      '{MaxPos,  -32'sd1,  1, MinNeg + 1, 1'b0},
      '{MinNeg,   MinNeg,  1, 32'sd1,  1'b0},
      '{MaxPos,   MaxPos,  1, 32'sd1,  1'b0},
      '{MaxPos,   MinNeg,  1, 32'sd0,  1'b0},
      '{MinNeg,   MaxPos,  1, -32'sd1, 1'b0},
      '{32'sd0,  -32'sd5,  1, 32'sd0,  1'b0},
      '{32'sd7,   32'sd2,  0, 32'sd0,  1'b0},
      '{-32'sd7,  32'sd2,  0, 32'sd0,  1'b0},
      '{32'sd7,  -32'sd2,  0, 32'sd0,  1'b0},
      '{-32'sd7, -32'sd2,  0, 32'sd0,  1'b0},
      '{32'sd100, 32'sd3,  0, 32'sd0,  1'b0},
      '{32'sd3,   32'sd100, 0, 32'sd0, 1'b0},
      '{-32'sd1, 32'sd1,   0, 32'sd0,  1'b0}
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      if (rows[i].known) begin
        e.quotient = rows[i].quotient;
        e.divide_by_zero = rows[i].dbz;
      end else begin
        e = predict_quotient(rows[i].dividend, rows[i].divisor);
      end
      send_request(rows[i].dividend, rows[i].divisor, e);
    end
    for (int n = 0; n < NumRandom; n++) begin
      a = rand_operand();
      b = ($urandom_range(0, 31) == 0) ? '0 : rand_operand();
      if (a == MinNeg && $urandom_range(0, 1)) a = a + 1;
      if (b == MinNeg && $urandom_range(0, 1)) b = b + 1;
      send_request(a, b, predict_quotient(a, b));
    end
    req_valid <= 1'b0;
    while (quotient_queue.size() != 0) @(posedge clk);
    repeat (Latency + 20) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
